// File: hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/valt_pkg.sv
// shared types, constants and tables for the axle load / tire force pipeline
// no dependencies
`default_nettype none

package valt_pkg;

    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASS       = 3'd0,
        CFG_FRONT_DIST = 3'd1,
        CFG_REAR_DIST  = 3'd2,
        CFG_COG_HEIGHT = 3'd3,
        CFG_GRAVITY    = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FRICTION = 2'd1,
        ERR_ZERO_VX  = 2'd2
    } err_code_t;

    localparam logic [CFG_W-1:0] RST_MASS       = 31'd65536000;
    localparam logic [CFG_W-1:0] RST_FRONT_DIST = 31'd78643;
    localparam logic [CFG_W-1:0] RST_REAR_DIST  = 31'd98304;
    localparam logic [CFG_W-1:0] RST_COG_HEIGHT = 31'd32768;
    localparam logic [CFG_W-1:0] RST_GRAVITY    = 31'd642908;

    localparam int MU_W = 18;
    localparam logic [MU_W-1:0] MU_LIMIT = 18'd163840;
    localparam int BC_W = 21;

    // cordic
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_XBITS = 40;
    localparam int CORDIC_ONE   = 32;
    localparam int ANGLE_W      = 25;
    localparam int LAT_CORDIC   = CORDIC_STEPS + 2;

    // divider: 33 quotient bits, overflow stage and rounding stage
    localparam int DIV_QBITS = 33;
    localparam int LAT_DIV   = DIV_QBITS + 2;
    localparam int DIVA_NW   = 94;
    localparam int DIVA_DW   = 56;
    localparam int DIVB_NW   = 58;
    localparam int DIVB_DW   = 40;

    // stage numbers counted from the input register
    localparam int ST_DIVA_IN = 4;
    localparam int ST_FZ      = ST_DIVA_IN + LAT_DIV;
    localparam int ST_CF      = ST_FZ + 3;
    localparam int ST_Z       = 3 + LAT_CORDIC;
    localparam int ST_DIVB_IN = ST_Z + 1;
    localparam int LAT_TOTAL  = ST_DIVB_IN + LAT_DIV;

    function automatic logic [23:0] atan_entry(input int i);
        logic [23:0] a;
        case (i)
            0:  a = 24'd13176795;
            1:  a = 24'd7778716;
            2:  a = 24'd4110060;
            3:  a = 24'd2086331;
            4:  a = 24'd1047214;
            5:  a = 24'd524117;
            6:  a = 24'd262123;
            7:  a = 24'd131069;
            8:  a = 24'd65536;
            9:  a = 24'd32768;
            10: a = 24'd16384;
            11: a = 24'd8192;
            12: a = 24'd4096;
            13: a = 24'd2048;
            14: a = 24'd1024;
            15: a = 24'd512;
            16: a = 24'd256;
            17: a = 24'd128;
            18: a = 24'd64;
            19: a = 24'd32;
            20: a = 24'd16;
            21: a = 24'd8;
            22: a = 24'd4;
            23: a = 24'd2;
            default: a = 24'd0;
        endcase
        return a;
    endfunction

    // B*C in Q.16 per friction band
    function automatic logic [BC_W-1:0] band_bc(input logic [MU_W-1:0] mu);
        logic [BC_W-1:0] bc;
        if (mu < 18'd19661)
            bc = 21'd524288;
        else if (mu < 18'd32768)
            bc = 21'd655360;
        else if (mu < 18'd58983)
            bc = 21'd1808794;
        else if (mu < 18'd98304)
            bc = 21'd1245184;
        else
            bc = 21'd1135922;
        return bc;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/valt_dly.sv
// fixed-depth alignment delay with a common advance enable
// depends on valt_pkg
`default_nettype none

module valt_dly #(
    parameter int W = valt_pkg::MU_W,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    import valt_pkg::*;

    logic [W-1:0] tap_reg [0:D-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < D; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[D-1];

endmodule

`default_nettype wire

// File: hw/rtl/valt_div.sv
// pipelined restoring divider, one quotient bit per stage
// rounds to nearest (ties away), applies sign and saturates to 32 bits; uses valt_pkg
`default_nettype none

module valt_div #(
    parameter int NW = valt_pkg::DIVA_NW,
    parameter int DW = valt_pkg::DIVA_DW
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic          neg,
    output logic [31:0]   quo
);
    import valt_pkg::*;

    localparam int QB = DIV_QBITS;
    localparam int CW = (NW > DW + QB) ? NW : DW + QB;
    localparam logic [QB:0] POS_MAX = (QB+1)'(32'h7FFF_FFFF);
    localparam logic [QB:0] NEG_MAX = (QB+1)'(32'h8000_0000);

    logic [DW-1:0] rem_reg [0:QB];
    logic [DW-1:0] d_reg   [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic [QB-1:0] low_reg [0:QB-1];
    logic          neg_reg [0:QB];
    logic          ovf_reg [0:QB];
    logic [31:0]   quo_reg;

    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_sh;

    always_comb
    begin
        num_ext = CW'(num);
        den_sh  = CW'(den) << QB;
    end

    // quotient of 2^33 or more saturates in any case
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= num_ext >= den_sh;
            rem_reg[0] <= DW'(num_ext >> QB);
            low_reg[0] <= num[QB-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DW:0] trial;
        logic        fits;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][QB-1]};
            fits  = trial >= {1'b0, d_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= fits ? DW'(trial - {1'b0, d_reg[k]}) : DW'(trial);
                q_reg[k+1]   <= {q_reg[k][QB-2:0], fits};
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < QB - 1)
        begin : g_low
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[k+1] <= low_reg[k] << 1;
                end
            end
        end
    end

    logic        rnd;
    logic [QB:0] q_rnd;
    logic [QB:0] lim;
    logic [QB:0] mag;
    logic [31:0] quo_next;

    always_comb
    begin
        rnd   = rem_reg[QB] >= (d_reg[QB] - rem_reg[QB]);
        q_rnd = (QB+1)'(q_reg[QB]) + (QB+1)'(rnd);
        lim   = neg_reg[QB] ? NEG_MAX : POS_MAX;
        mag   = (ovf_reg[QB] || q_rnd > lim) ? lim : q_rnd;
        quo_next = neg_reg[QB] ? (32'd0 - mag[31:0]) : mag[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// File: hw/rtl/valt_cordic.sv
// pipelined arctangent of an unsigned Q.32 magnitude, result in Q.24
// range reduction stage, then one cordic vectoring iteration per stage; uses valt_pkg
`default_nettype none

module valt_cordic (
    input  logic                        clk,
    input  logic                        en,
    input  logic [63:0]                 xm,
    output logic [valt_pkg::ANGLE_W-1:0] angle
);
    import valt_pkg::*;

    localparam int XW = 64;
    localparam int CW = 44;
    localparam int ZW = ANGLE_W + 1;
    localparam int SW = 5;
    localparam logic [XW-1:0] ONE = XW'(1) << CORDIC_ONE;

    logic [XW-1:0] xm_reg;
    logic [SW-1:0] sh_reg;
    logic          zero_reg;
    logic [SW-1:0] sh_next;

    logic signed [CW-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg  [0:CORDIC_STEPS];
    logic                 zs_reg [0:CORDIC_STEPS];

    // halve magnitude and unit together until magnitude is below 2^40
    always_comb
    begin
        sh_next = '0;
        for (int b = CORDIC_XBITS; b < XW; b++)
        begin
            if (xm[b])
            begin
                sh_next = SW'(b - CORDIC_XBITS + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm_reg   <= xm;
            sh_reg   <= sh_next;
            zero_reg <= xm == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= CW'(ONE >> sh_reg);
            cy_reg[0] <= CW'(xm_reg >> sh_reg);
            z_reg[0]  <= '0;
            zs_reg[0] <= zero_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [ZW-1:0] step;

        always_comb
        begin
            step = $signed(ZW'(atan_entry(i)));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy_reg[i][CW-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    z_reg[i+1]  <= z_reg[i] - step;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    z_reg[i+1]  <= z_reg[i] + step;
                end
                zs_reg[i+1] <= zs_reg[i];
            end
        end
    end

    // angle clamps at zero and is exactly zero for a zero argument
    assign angle = (zs_reg[CORDIC_STEPS] || z_reg[CORDIC_STEPS][ZW-1]) ? '0
                 : z_reg[CORDIC_STEPS][ZW-2:0];

endmodule

`default_nettype wire

// File: hw/rtl/vehicle_axle_load_tire_force.sv
// top level: axle loads, rear lateral force and front cornering stiffness per trajectory point
// depends on valt_pkg, valt_dly, valt_div, valt_cordic
`default_nettype none

// Takes one trajectory point per clock and returns one result item for each, in order,
// through 65 register stages, the input register being the first. The depth is set by the rear
// lateral force path: three input stages, a 26-stage arctangent pipeline (range reduction,
// start and 24 iterations), a numerator stage and a 35-stage divider (one quotient bit per
// stage). The normal forces use two more dividers of the same depth; the front normal force
// alone feeds the front stiffness multiplier. When the output item is not taken the whole
// pipeline holds and the input is not ready; otherwise a new item enters every cycle.
// Configuration writes take effect at once and are meant to be made while no item is in
// flight.
module vehicle_axle_load_tire_force (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [valt_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [valt_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // front_long_force, rear_long_force, rear_stiffness, yaw_rate, lateral_velocity,
    // longitudinal_velocity, friction_coeff, zero pad
    input  logic [215:0]                s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // front_normal_force, rear_normal_force, rear_lateral_force, front_stiffness
    output logic [127:0]                m_axis_tdata,
    // error_code
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);
    import valt_pkg::*;

    // configuration
    logic [CFG_W-1:0] mass_reg, lf_reg, lr_reg, h_reg, g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg <= RST_MASS;
            lf_reg   <= RST_FRONT_DIST;
            lr_reg   <= RST_REAR_DIST;
            h_reg    <= RST_COG_HEIGHT;
            g_reg    <= RST_GRAVITY;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_MASS:       mass_reg <= cfg_wdata;
                CFG_FRONT_DIST: lf_reg   <= cfg_wdata;
                CFG_REAR_DIST:  lr_reg   <= cfg_wdata;
                CFG_COG_HEIGHT: h_reg    <= cfg_wdata;
                CFG_GRAVITY:    g_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits and pipeline advance
    logic                 en;
    logic [LAT_TOTAL:1]   vld_reg;

    assign en = !vld_reg[LAT_TOTAL] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT_TOTAL-1:1], s_axis_tvalid};
        end
    end

    // input fields
    logic signed [31:0] ffx, frx, cr_in, yaw_in, vy_in, vx_in;
    logic [MU_W-1:0]    mu_in;

    always_comb
    begin
        ffx    = $signed(s_axis_tdata[31:0]);
        frx    = $signed(s_axis_tdata[63:32]);
        cr_in  = $signed(s_axis_tdata[95:64]);
        yaw_in = $signed(s_axis_tdata[127:96]);
        vy_in  = $signed(s_axis_tdata[159:128]);
        vx_in  = $signed(s_axis_tdata[191:160]);
        mu_in  = s_axis_tdata[209:192];
    end

    // stage 1
    logic signed [32:0] fsum_reg;
    logic [61:0]        mg_reg;
    logic signed [63:0] lrr_reg;
    logic signed [31:0] vy_reg;
    logic [31:0]        cr_reg, vx_reg;
    logic [MU_W-1:0]    mu_reg;
    err_code_t          err_reg;
    logic               last_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fsum_reg <= 33'(ffx) + 33'(frx);
            mg_reg   <= mass_reg * g_reg;
            lrr_reg  <= $signed({1'b0, lr_reg}) * yaw_in;
            vy_reg   <= vy_in;
            cr_reg   <= cr_in;
            vx_reg   <= vx_in;
            mu_reg   <= mu_in;
            last_reg <= s_axis_tlast;
            if (mu_in >= MU_LIMIT)
                err_reg <= ERR_FRICTION;
            else if (vx_in == '0)
                err_reg <= ERR_ZERO_VX;
            else
                err_reg <= ERR_NONE;
        end
    end

    // stage 2: products split to 31-bit halves
    logic [32:0]        fabs;
    logic [63:0]        t0_reg;
    logic [61:0]        mglr_lo_reg, mglr_hi_reg, mglf_lo_reg, mglf_hi_reg;
    logic               fneg2_reg, fpos2_reg;
    logic signed [63:0] x_reg;

    assign fabs = fsum_reg[32] ? 33'(-fsum_reg) : 33'(fsum_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg      <= fabs * h_reg;
            mglr_lo_reg <= mg_reg[30:0] * lr_reg;
            mglr_hi_reg <= mg_reg[61:31] * lr_reg;
            mglf_lo_reg <= mg_reg[30:0] * lf_reg;
            mglf_hi_reg <= mg_reg[61:31] * lf_reg;
            fneg2_reg   <= fsum_reg[32];
            fpos2_reg   <= !fsum_reg[32] && (fsum_reg != '0);
            x_reg       <= lrr_reg - (64'(vy_reg) <<< 16);
        end
    end

    // stage 3
    logic [92:0] mglr_reg, mglf_reg;
    logic [87:0] t_reg;
    logic        fneg3_reg, fpos3_reg;
    logic [63:0] xm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mglr_reg  <= 93'(mglr_lo_reg) + (93'(mglr_hi_reg) << 31);
            mglf_reg  <= 93'(mglf_lo_reg) + (93'(mglf_hi_reg) << 31);
            t_reg     <= {t0_reg, 24'd0};
            fneg3_reg <= fneg2_reg;
            fpos3_reg <= fpos2_reg;
            xm_reg    <= x_reg[63] ? 64'(-x_reg) : 64'(x_reg);
        end
    end

    // stage 4: load transfer numerators as magnitude and sign
    logic [DIVA_NW-1:0] ta, bf, br, nf_next, nr_next;
    logic               negf_next, negr_next;
    logic [31:0]        axle;
    logic [DIVA_NW-1:0] nf_reg, nr_reg;
    logic               negf_reg, negr_reg;
    logic [DIVA_DW-1:0] dena_reg;

    always_comb
    begin
        ta = DIVA_NW'(t_reg);
        bf = DIVA_NW'(mglr_reg);
        br = DIVA_NW'(mglf_reg);
        negf_next = 1'b0;
        negr_next = 1'b0;
        // front: weight share minus transfer when the force sum is negative
        if (!fneg3_reg)
            nf_next = ta + bf;
        else if (bf >= ta)
            nf_next = bf - ta;
        else
        begin
            nf_next   = ta - bf;
            negf_next = 1'b1;
        end
        // rear: transfer subtracts when the force sum is positive
        if (!fpos3_reg)
            nr_next = ta + br;
        else if (br >= ta)
            nr_next = br - ta;
        else
        begin
            nr_next   = ta - br;
            negr_next = 1'b1;
        end
        axle = 32'(lf_reg) + 32'(lr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // zero axle sum gives zero loads
            if (axle == '0)
            begin
                nf_reg   <= '0;
                nr_reg   <= '0;
                dena_reg <= DIVA_DW'(1);
            end
            else
            begin
                nf_reg   <= nf_next;
                nr_reg   <= nr_next;
                dena_reg <= {axle, 24'd0};
            end
            negf_reg <= negf_next;
            negr_reg <= negr_next;
        end
    end

    logic [31:0] fzf, fzr;

    valt_div #(.NW(DIVA_NW), .DW(DIVA_DW)) u_div_front (
        .clk (clk),
        .en  (en),
        .num (nf_reg),
        .den (dena_reg),
        .neg (negf_reg),
        .quo (fzf)
    );

    valt_div #(.NW(DIVA_NW), .DW(DIVA_DW)) u_div_rear (
        .clk (clk),
        .en  (en),
        .num (nr_reg),
        .den (dena_reg),
        .neg (negr_reg),
        .quo (fzr)
    );

    // front stiffness from the front load
    logic [MU_W-1:0] mu_d;

    valt_dly #(.W(MU_W), .D(ST_FZ - 1)) u_dly_mu (
        .clk (clk), .en (en), .din (mu_reg), .dout (mu_d)
    );

    logic [BC_W-1:0]        bc;
    logic [BC_W+MU_W-1:0]   p_reg;
    logic [31:0]            fmag_reg;
    logic                   fsn_reg;

    always_comb
    begin
        bc = (mu_d >= MU_LIMIT) ? '0 : band_bc(mu_d);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= bc * mu_d;
            fsn_reg  <= fzf[31];
            fmag_reg <= fzf[31] ? (32'd0 - fzf) : fzf;
        end
    end

    logic [63:0] pl_reg;
    logic [38:0] ph_reg;
    logic        fsn2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg   <= p_reg[31:0] * fmag_reg;
            ph_reg   <= p_reg[38:32] * fmag_reg;
            fsn2_reg <= fsn_reg;
        end
    end

    logic [70:0] cn;
    logic [39:0] cq, clim, cmag;
    logic [31:0] cf_reg;

    always_comb
    begin
        cn   = 71'(pl_reg) + (71'(ph_reg) << 32);
        cq   = 40'(cn[70:32]) + 40'(cn[31]);
        clim = fsn2_reg ? 40'h80000000 : 40'h7FFFFFFF;
        cmag = (cq > clim) ? clim : cq;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cf_reg <= fsn2_reg ? (32'd0 - cmag[31:0]) : cmag[31:0];
        end
    end

    // rear lateral force path
    logic [ANGLE_W-1:0] angle;

    valt_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .xm    (xm_reg),
        .angle (angle)
    );

    logic [31:0] cr_d, vx_d;
    logic        xneg_d;

    valt_dly #(.W(32), .D(ST_Z - 1)) u_dly_cr (
        .clk (clk), .en (en), .din (cr_reg), .dout (cr_d)
    );

    valt_dly #(.W(32), .D(ST_Z - 1)) u_dly_vx (
        .clk (clk), .en (en), .din (vx_reg), .dout (vx_d)
    );

    valt_dly #(.W(1), .D(ST_Z - 2)) u_dly_xneg (
        .clk (clk), .en (en), .din (x_reg[63]), .dout (xneg_d)
    );

    logic [31:0]        crm, vxm;
    logic               sgn_l;
    logic [DIVB_NW-1:0] numl_next;
    logic [DIVB_NW-1:0] numl_reg;
    logic [DIVB_DW-1:0] denl_reg;
    logic               sgnl_reg;

    always_comb
    begin
        crm   = cr_d[31] ? (32'd0 - cr_d) : cr_d;
        vxm   = vx_d[31] ? (32'd0 - vx_d) : vx_d;
        sgn_l = cr_d[31] ^ xneg_d;
        numl_next = {(DIVB_NW-1)'(crm * angle), 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // zero speed: any nonzero numerator becomes all ones over one, so it saturates
            if (vx_d == '0)
            begin
                numl_reg <= (numl_next == '0) ? '0 : '1;
                denl_reg <= DIVB_DW'(1);
                sgnl_reg <= sgn_l;
            end
            else
            begin
                numl_reg <= numl_next;
                denl_reg <= {vxm, 8'd0};
                sgnl_reg <= sgn_l ^ vx_d[31];
            end
        end
    end

    logic [31:0] fyr;

    valt_div #(.NW(DIVB_NW), .DW(DIVB_DW)) u_div_lat (
        .clk (clk),
        .en  (en),
        .num (numl_reg),
        .den (denl_reg),
        .neg (sgnl_reg),
        .quo (fyr)
    );

    // align the remaining fields with the lateral force
    logic [31:0] fzf_d, fzr_d, cf_d;
    logic [1:0]  err_d;
    logic        last_d;

    valt_dly #(.W(32), .D(LAT_TOTAL - ST_FZ)) u_dly_fzf (
        .clk (clk), .en (en), .din (fzf), .dout (fzf_d)
    );

    valt_dly #(.W(32), .D(LAT_TOTAL - ST_FZ)) u_dly_fzr (
        .clk (clk), .en (en), .din (fzr), .dout (fzr_d)
    );

    valt_dly #(.W(32), .D(LAT_TOTAL - ST_CF)) u_dly_cf (
        .clk (clk), .en (en), .din (cf_reg), .dout (cf_d)
    );

    valt_dly #(.W(2), .D(LAT_TOTAL - 1)) u_dly_err (
        .clk (clk), .en (en), .din (err_reg), .dout (err_d)
    );

    valt_dly #(.W(1), .D(LAT_TOTAL - 1)) u_dly_last (
        .clk (clk), .en (en), .din (last_reg), .dout (last_d)
    );

    assign m_axis_tvalid = vld_reg[LAT_TOTAL];
    assign m_axis_tdata  = {cf_d, fyr, fzr_d, fzf_d};
    assign m_axis_tuser  = err_d;
    assign m_axis_tlast  = last_d;

endmodule

`default_nettype wire

// File: hw/rtl/valt_chk.sv
// port-level checks for vehicle_axle_load_tire_force, attached by bind
// depends on valt_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module valt_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import valt_pkg::*;

    // a stalled result item stays and holds its data
    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // input is ready whenever the output side can move
    `ASSERT_IMPL(a_in_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready)
    // friction error forces a zero front stiffness
    `ASSERT_IMPL(a_fric_zero, m_axis_tvalid && m_axis_tuser == ERR_FRICTION,
                 m_axis_tdata[127:96] == 32'd0)

endmodule

bind vehicle_axle_load_tire_force valt_chk u_valt_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: bench/testbench.sv
// testbench for vehicle_axle_load_tire_force: directed table, then random trajectory points
// checked against a bit-exact predictor of the axle loads, lateral force and stiffness
// depends on valt_pkg and the block's rtl
`timescale 1ns / 100ps

module testbench;
    import valt_pkg::*;

    typedef struct packed {
        logic signed [31:0] fxf;
        logic signed [31:0] fxr;
        logic signed [31:0] cr;
        logic signed [31:0] yaw;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
        logic [17:0]        mu;
        logic               last;
    } point_t;

    typedef struct packed {
        logic [31:0] fzf;
        logic [31:0] fzr;
        logic [31:0] fyr;
        logic [31:0] cf;
        err_code_t   err;
        logic        last;
    } loads_t;

    typedef struct {
        point_t      p;
        bit          typed;
        logic [31:0] fyr;
        logic [31:0] cf;
        err_code_t   err;
    } row_t;

    localparam logic [23:0] ATAN_Q24 [24] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
        24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192, 24'd4096,
        24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128, 24'd64, 24'd32, 24'd16, 24'd8,
        24'd4, 24'd2};
    localparam logic [17:0] BAND_TOP [4] = '{18'd19661, 18'd32768, 18'd58983, 18'd98304};
    localparam logic [20:0] BAND_BC [5] = '{21'd524288, 21'd655360, 21'd1808794,
                                            21'd1245184, 21'd1135922};

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;

    vehicle_axle_load_tire_force dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // vehicle parameters as the block should hold them
    logic [30:0] veh_mass, dist_front, dist_rear, cg_height, grav;

    loads_t pending_loads[$];
    int     mismatches;
    bit     failed;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_req;
    int     hold_cycles;
    int     points_sent;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] round_div_sat(logic [127:0] n, logic [127:0] d, bit neg);
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] lim;
        q = n / d;
        rem = n % d;
        if (rem >= d - rem)
            q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // vectoring cordic, angle of xm / 2^32 in Q.24
    function automatic longint atan_q24(logic [63:0] xm);
        logic [63:0] one;
        longint cx, cy, z, nx;
        one = 64'd1 << 32;
        z = 0;
        if (xm == 0)
            return 0;
        while (xm >= (64'd1 << 40))
        begin
            xm = xm >> 1;
            one = one >> 1;
        end
        cx = longint'(one);
        cy = longint'(xm);
        for (int i = 0; i < 24; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z = z + ATAN_Q24[i];
            end
            else
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z = z - ATAN_Q24[i];
            end
            cx = nx;
        end
        return z < 0 ? 0 : z;
    endfunction

    // b + a, or b - a when a is negative, as magnitude and sign
    function automatic logic [127:0] signed_sum(logic [127:0] a, bit aneg, logic [127:0] b,
                                                output bit neg);
        neg = 1'b0;
        if (!aneg)
            return a + b;
        if (b >= a)
            return b - a;
        neg = 1'b1;
        return a - b;
    endfunction

    function automatic loads_t predict_loads(point_t p);
        loads_t r;
        longint fsum, x;
        logic [127:0] axle, mg, t, n, fmag;
        logic [63:0] num;
        bit neg, xneg;
        int b;
        r = '0;
        r.err = ERR_NONE;
        r.last = p.last;
        fsum = longint'(p.fxf) + longint'(p.fxr);
        axle = 128'(dist_front) + 128'(dist_rear);
        mg = 128'(veh_mass) * 128'(grav);
        if (axle != 0)
        begin
            t = (128'(magnitude(fsum)) * 128'(cg_height)) << 24;
            n = signed_sum(t, fsum < 0, mg * 128'(dist_rear), neg);
            r.fzf = round_div_sat(n, axle << 24, neg);
            n = signed_sum(t, fsum > 0, mg * 128'(dist_front), neg);
            r.fzr = round_div_sat(n, axle << 24, neg);
        end
        x = longint'(dist_rear) * longint'(p.yaw) - longint'(p.vy) * 65536;
        xneg = x < 0;
        num = 64'd2 * magnitude(longint'(p.cr)) * 64'(atan_q24(magnitude(x)));
        neg = (p.cr < 0) != xneg;
        if (p.vx == 0)
        begin
            r.err = ERR_ZERO_VX;
            r.fyr = num == 0 ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
        else
            r.fyr = round_div_sat(128'(num), 128'(magnitude(longint'(p.vx))) << 8,
                                  neg != (p.vx < 0));
        if (p.mu >= MU_LIMIT)
            r.err = ERR_FRICTION;
        else
        begin
            fmag = r.fzf[31] ? (128'h1_0000_0000 - 128'(r.fzf)) : 128'(r.fzf);
            b = 0;
            while (b < 4 && p.mu >= BAND_TOP[b])
                b++;
            n = 128'(BAND_BC[b]) * 128'(p.mu) * fmag;
            r.cf = round_div_sat(n, 128'h1_0000_0000, r.fzf[31]);
        end
        return r;
    endfunction

    // receiver side: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req || hold_cycles > 0)
        begin
            if (hold_req)
            begin
                hold_cycles = 400;
                hold_req = 1'b0;
            end
            hold_cycles = hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge clk)
    begin
        loads_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.fzf = m_axis_tdata[31:0];
            got.fzr = m_axis_tdata[63:32];
            got.fyr = m_axis_tdata[95:64];
            got.cf = m_axis_tdata[127:96];
            got.err = err_code_t'(m_axis_tuser);
            got.last = m_axis_tlast;
            if (pending_loads.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %h", got);
            end
            else
            begin
                want = pending_loads.pop_front();
                if (got.fzf !== want.fzf || got.fzr !== want.fzr || got.fyr !== want.fyr ||
                    got.cf !== want.cf || got.err !== want.err || got.last !== want.last)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch fzf %h/%h fzr %h/%h fyr %h/%h cf %h/%h err %0d/%0d last %b/%b",
                                 want.fzf, got.fzf, want.fzr, got.fzr, want.fyr, got.fyr,
                                 want.cf, got.cf, want.err, got.err, want.last, got.last);
                end
            end
        end
    end

    task automatic send_point(point_t p, output loads_t predicted);
        send_idle_pct = points_sent < 380 ? 25 : (points_sent < 760 ? 51 : 0);
        recv_idle_pct = points_sent < 380 ? 51 : (points_sent < 760 ? 25 : 0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, p.mu, p.vx, p.vy, p.yaw, p.cr, p.fxr, p.fxf};
        s_axis_tlast <= p.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_loads(p);
        pending_loads = {pending_loads, predicted};
        points_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_loads.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_vehicle(logic [30:0] m, logic [30:0] lf, logic [30:0] lr,
                               logic [30:0] h, logic [30:0] g);
        logic [30:0] vals [5];
        vals = '{m, lf, lr, h, g};
        for (int i = 0; i < 5; i++)
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_addr <= cfg_idx_t'(i);
            cfg_wdata <= vals[i];
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        veh_mass = m;
        dist_front = lf;
        dist_rear = lr;
        cg_height = h;
        grav = g;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return 32'($urandom_range(1048575)) - 32'd524288;
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        logic [17:0] edges [10];
        edges = '{18'd19660, 18'd19661, 18'd32767, 18'd32768, 18'd58982, 18'd58983,
                  18'd98303, 18'd98304, 18'd163839, 18'd0};
        p.fxf = rand_word();
        p.fxr = rand_word();
        p.cr = rand_word();
        p.yaw = rand_word();
        p.vy = rand_word();
        p.vx = $urandom_range(11) == 0 ? 32'd0 : rand_word();
        case ($urandom_range(9))
            0: p.mu = 18'($urandom_range(262143, 163840));
            1: p.mu = edges[$urandom_range(9)];
            default: p.mu = 18'($urandom_range(163839));
        endcase
        p.last = $urandom_range(15) == 0;
        return p;
    endfunction

    row_t rows [$];

    initial
    begin
        loads_t pred;
        logic [30:0] cm [6];
        logic [30:0] cfd [6];
        logic [30:0] crd [6];
        logic [30:0] ch [6];
        logic [30:0] cg [6];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        hold_req = 1'b0;
        hold_cycles = 0;
        mismatches = 0;
        failed = 1'b0;
        points_sent = 0;
        send_idle_pct = 25;
        recv_idle_pct = 51;
        veh_mass = RST_MASS;
        dist_front = RST_FRONT_DIST;
        dist_rear = RST_REAR_DIST;
        cg_height = RST_COG_HEIGHT;
        grav = RST_GRAVITY;

        // fxf fxr cr yaw vy vx mu last; typed: fyr cf err
        rows = '{
            '{'{0, 0, 0, 0, 0, 0, 18'd0, 1'b0}, 1, 32'h0, 32'h0, ERR_ZERO_VX},
            '{'{0, 0, 0, 0, 0, 65536, 18'd163840, 1'b0}, 1, 32'h0, 32'h0, ERR_FRICTION},
            '{'{0, 0, 32'h7FFF_FFFF, 65536, 0, 0, 18'd262143, 1'b0}, 1,
              32'h7FFF_FFFF, 32'h0, ERR_FRICTION},
            '{'{0, 0, -1, 65536, 0, 0, 18'd0, 1'b1}, 1, 32'h8000_0000, 32'h0, ERR_ZERO_VX},
            '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 256000, 32768, -65536, 655360, 18'd19660, 1'b0},
              0, 0, 0, ERR_NONE},
            '{'{32'h8000_0000, 32'h8000_0000, -256000, -32768, 65536, -655360, 18'd19661, 1'b0},
              0, 0, 0, ERR_NONE},
            '{'{256000, -128000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 18'd32767,
                1'b0}, 0, 0, 0, ERR_NONE},
            '{'{-256000, 128000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -1, 18'd32768,
                1'b0}, 0, 0, 0, ERR_NONE},
            '{'{1000, 2000, 3000, 4000, 5000, 32'h7FFF_FFFF, 18'd58982, 1'b0}, 0, 0, 0, ERR_NONE},
            '{'{-1, -1, -1, -1, -1, 32'h8000_0000, 18'd58983, 1'b1}, 0, 0, 0, ERR_NONE},
            '{'{500000, 500000, 2000000, 13107, 6553, 1310720, 18'd98303, 1'b0},
              0, 0, 0, ERR_NONE},
            '{'{-500000, 0, 2000000, -13107, -6553, 1310720, 18'd98304, 1'b0},
              0, 0, 0, ERR_NONE},
            '{'{0, 0, 1, 1, 0, 65536, 18'd163839, 1'b0}, 0, 0, 0, ERR_NONE},
            '{'{32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 18'd65536, 1'b1},
              0, 0, 0, ERR_NONE}
        };

        cm = '{31'd0, 31'h7FFF_FFFF, 31'd65536000, 31'd1, 31'd98304000, 31'd70000000};
        cfd = '{31'd78643, 31'h7FFF_FFFF, 31'd0, 31'd1, 31'd65536, 31'd100000};
        crd = '{31'd98304, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd131072, 31'd1};
        ch = '{31'd32768, 31'h7FFF_FFFF, 31'd32768, 31'd0, 31'd45000, 31'd5};
        cg = '{31'd642908, 31'h7FFF_FFFF, 31'd642908, 31'd0, 31'd642908, 31'd1};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            send_point(rows[i].p, pred);
            if (rows[i].typed && (pred.fyr !== rows[i].fyr || pred.cf !== rows[i].cf ||
                                  pred.err !== rows[i].err))
            begin
                failed = 1'b1;
                $display("row %0d: predicted fyr %h cf %h err %0d differ from table",
                         i, pred.fyr, pred.cf, pred.err);
            end
        end
        wait_drained();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
                set_vehicle(cm[ph-1], cfd[ph-1], crd[ph-1], ch[ph-1], cg[ph-1]);
            // long receiver hold-off while points keep coming, so the pipeline backs up
            if (ph == 3)
                hold_req = 1'b1;
            for (int k = 0; k < 163; k++)
                send_point(rand_point(), pred);
            wait_drained();
        end

        repeat (LAT_TOTAL + 20) @(posedge clk);
        if (!failed && pending_loads.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
